// ===== hdl/tkce_pkg.sv =====
// Shared types, constants and message tables for the touch key command encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
package tkce_pkg;

    localparam int NUM_CH    = 10;
    localparam int NUM_SLOTS = 11;
    localparam int CNT_W     = 16;
    localparam int CHAR_W    = 8;

    // Sensor channel of each key.
    localparam int CH_L1       = 0;
    localparam int CH_L3       = 1;
    localparam int CH_L2       = 2;
    localparam int CH_L4       = 3;
    localparam int CH_FAN_ONE  = 4;
    localparam int CH_UP       = 5;
    localparam int CH_DOWN     = 6;
    localparam int CH_FAN_TWO  = 7;
    localparam int CH_UP_TWO   = 8;
    localparam int CH_DOWN_TWO = 9;

    localparam logic [CNT_W-1:0]  LONG_PRESS_RESET = 16'd200;
    localparam logic [CNT_W-1:0]  CNT_MAX          = 16'hFFFF;
    localparam logic [CHAR_W-1:0] CRC_POLY         = 8'h07;
    localparam logic [CHAR_W-1:0] CRC_INIT         = 8'h00;
    localparam logic [CHAR_W-1:0] CRC_MSB          = 8'h80;

    localparam logic [CHAR_W-1:0] CHAR_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_U    = 8'h55;
    localparam logic [CHAR_W-1:0] CHAR_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CHAR_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_FAN_ONE    = 2'd1;
    localparam logic [1:0] REG_FAN_TWO    = 2'd2;

    // Message slots in the order they leave the block.
    typedef enum logic [3:0] {
        SLOT_L1,
        SLOT_L2,
        SLOT_L3,
        SLOT_L4,
        SLOT_FAN_ONE,
        SLOT_UP_SHORT,
        SLOT_DOWN_SHORT,
        SLOT_FAN_TWO,
        SLOT_UP_TWO,
        SLOT_DOWN_TWO,
        SLOT_LONG
    } t_slot;

    // First character sits in the low byte so the struct is the output tdata.
    typedef struct packed {
        logic [CHAR_W-1:0] check;
        logic [CHAR_W-1:0] second;
        logic [CHAR_W-1:0] first;
    } t_msg;

    // One scan's worth of pending messages plus the fan phases it was sent with.
    typedef struct packed {
        logic                 fan_two;
        logic                 fan_one;
        logic [NUM_SLOTS-1:0] mask;
    } t_batch;

    typedef struct packed {
        logic fire;
        logic at_long;
    } t_hold_status;

    function automatic logic [CHAR_W-1:0] crc8_update(input logic [CHAR_W-1:0] crc_in,
                                                      input logic [CHAR_W-1:0] data);
        logic [CHAR_W-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((crc & CRC_MSB) != 8'h00) begin
                crc = (crc << 1) ^ CRC_POLY;
            end else begin
                crc = crc << 1;
            end
        end
        return crc;
    endfunction

    // Characters and check byte of a slot; the phase only matters for fan slots.
    function automatic t_msg msg_entry(input t_slot slot, input logic phase);
        t_msg m;
        m.first  = 8'h00;
        m.second = 8'h00;
        case (slot)
            SLOT_L1:         begin m.first = CHAR_L; m.second = CHAR_ZERO + 8'd1; end
            SLOT_L2:         begin m.first = CHAR_L; m.second = CHAR_ZERO + 8'd2; end
            SLOT_L3:         begin m.first = CHAR_L; m.second = CHAR_ZERO + 8'd3; end
            SLOT_L4:         begin m.first = CHAR_L; m.second = CHAR_ZERO + 8'd4; end
            SLOT_FAN_ONE:    begin m.first = CHAR_F; m.second = CHAR_ZERO + {7'd0, phase}; end
            SLOT_UP_SHORT:   begin m.first = CHAR_U; m.second = CHAR_ZERO + 8'd1; end
            SLOT_DOWN_SHORT: begin m.first = CHAR_D; m.second = CHAR_ZERO + 8'd1; end
            SLOT_FAN_TWO:    begin
                m.first  = CHAR_F;
                m.second = CHAR_ZERO + 8'd2 + {7'd0, phase};
            end
            SLOT_UP_TWO:     begin m.first = CHAR_U; m.second = CHAR_ZERO + 8'd2; end
            SLOT_DOWN_TWO:   begin m.first = CHAR_D; m.second = CHAR_ZERO + 8'd2; end
            SLOT_LONG:       begin m.first = CHAR_P; m.second = CHAR_ZERO + 8'd1; end
            default:         begin m.first = 8'h00; m.second = 8'h00; end
        endcase
        m.check = crc8_update(crc8_update(CRC_INIT, m.first), m.second);
        return m;
    endfunction

endpackage

// ===== hdl/touch_key_command_encoder_unit.sv =====
// Top level of the touch key command encoder: edge lanes, hold lanes, config port.
// Depends on tkce_pkg, tkce_hold_lane and tkce_merge.
//
// Each input beat is one finished scan of ten touch channels. The block compares
// it with the previous scan and produces up to eleven three-byte command messages
// (two ASCII characters and a CRC-8, polynomial 0x07, initial value 0) in fixed key
// order: L1, L2, L3, L4, fan one, U1, D1, fan two, U2, D2, P1. The last message of
// a scan carries tlast; a scan with no edges produces nothing. A scan that causes n
// messages sends them one per beat while m_axis_tready is high, taken from a
// drain register in the merging stage. The input is taken on the cycle it arrives
// while the one-scan holding register in front of that drain is free, so a new scan
// can be accepted while the previous scan's messages are still leaving. The first
// message of a scan is offered from the drain register after it has passed through
// the holding register, when the drain is idle. Configuration: register 0 (address
// 0x0) is the long-press threshold, registers 1 and 2 (0x4, 0x8) load the fan
// toggle phases at once. Write them only while the block is idle.
module touch_key_command_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Scan input. tdata: [9:0] touched, [15:10] zero.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Messages. tdata: [7:0] first_char, [15:8] second_char, [23:16] check_byte.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [tkce_pkg::NUM_CH-1:0] r_prev;
    logic                        r_fan_one;
    logic                        r_fan_two;
    logic [tkce_pkg::CNT_W-1:0]  r_ticks;
    logic                        r_fan_one_start;
    logic                        r_fan_two_start;

    logic [tkce_pkg::NUM_CH-1:0]    cur;
    logic [tkce_pkg::NUM_CH-1:0]    rise;
    logic                           accept;
    logic                           p_fire;
    logic                           cfg_we;
    logic [1:0]                     cfg_idx;
    logic [tkce_pkg::NUM_SLOTS-1:0] mask;
    tkce_pkg::t_hold_status         up_status;
    tkce_pkg::t_hold_status         down_status;
    tkce_pkg::t_batch               batch;
    tkce_pkg::t_msg                 msg;

    assign cur    = s_axis_tdata[tkce_pkg::NUM_CH-1:0];
    assign rise   = cur & ~r_prev;
    assign accept = s_axis_tvalid && s_axis_tready;

    // The two hold keys each get a lane; both see every accepted scan.
    tkce_hold_lane u_up_lane (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_now        (cur[tkce_pkg::CH_UP]),
        .i_before     (r_prev[tkce_pkg::CH_UP]),
        .i_ticks      (r_ticks),
        .i_step       (accept),
        .i_long_clear (p_fire),
        .o_status     (up_status)
    );

    tkce_hold_lane u_down_lane (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_now        (cur[tkce_pkg::CH_DOWN]),
        .i_before     (r_prev[tkce_pkg::CH_DOWN]),
        .i_ticks      (r_ticks),
        .i_step       (accept),
        .i_long_clear (p_fire),
        .o_status     (down_status)
    );

    // A long press needs both counts at the threshold after this scan's update.
    assign p_fire = up_status.at_long && down_status.at_long;

    always_comb begin
        mask                              = '0;
        mask[tkce_pkg::SLOT_L1]           = rise[tkce_pkg::CH_L1];
        mask[tkce_pkg::SLOT_L2]           = rise[tkce_pkg::CH_L2];
        mask[tkce_pkg::SLOT_L3]           = rise[tkce_pkg::CH_L3];
        mask[tkce_pkg::SLOT_L4]           = rise[tkce_pkg::CH_L4];
        mask[tkce_pkg::SLOT_FAN_ONE]      = rise[tkce_pkg::CH_FAN_ONE];
        mask[tkce_pkg::SLOT_UP_SHORT]     = up_status.fire;
        mask[tkce_pkg::SLOT_DOWN_SHORT]   = down_status.fire;
        mask[tkce_pkg::SLOT_FAN_TWO]      = rise[tkce_pkg::CH_FAN_TWO];
        mask[tkce_pkg::SLOT_UP_TWO]       = rise[tkce_pkg::CH_UP_TWO];
        mask[tkce_pkg::SLOT_DOWN_TWO]     = rise[tkce_pkg::CH_DOWN_TWO];
        mask[tkce_pkg::SLOT_LONG]         = p_fire;
        // Fan messages use the phase held before this scan toggles it.
        batch.mask    = mask;
        batch.fan_one = r_fan_one;
        batch.fan_two = r_fan_two;
    end

    tkce_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid && (mask != '0)),
        .o_ready (s_axis_tready),
        .i_batch (batch),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_msg   (msg),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = msg;

    // Configuration port: zero-wait writes, combinational read data.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            tkce_pkg::REG_LONG_PRESS: prdata = {16'd0, r_ticks};
            tkce_pkg::REG_FAN_ONE:    prdata = {31'd0, r_fan_one_start};
            tkce_pkg::REG_FAN_TWO:    prdata = {31'd0, r_fan_two_start};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev          <= '0;
            r_fan_one       <= 1'b0;
            r_fan_two       <= 1'b0;
            r_ticks         <= tkce_pkg::LONG_PRESS_RESET;
            r_fan_one_start <= 1'b0;
            r_fan_two_start <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    tkce_pkg::REG_LONG_PRESS: r_ticks <= pwdata[15:0];
                    tkce_pkg::REG_FAN_ONE: begin
                        r_fan_one_start <= pwdata[0];
                        r_fan_one       <= pwdata[0];
                    end
                    tkce_pkg::REG_FAN_TWO: begin
                        r_fan_two_start <= pwdata[0];
                        r_fan_two       <= pwdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_prev <= cur;
                if (rise[tkce_pkg::CH_FAN_ONE]) begin
                    r_fan_one <= ~r_fan_one;
                end
                if (rise[tkce_pkg::CH_FAN_TWO]) begin
                    r_fan_two <= ~r_fan_two;
                end
            end
        end
    end

    // More messages of a scan always follow a beat that is not the last one.
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
        else $error("message run ended without tlast");

    // The input only stalls while messages are waiting at the output.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with nothing to send");

    // A scan with edges has the output busy after passing through the holding register,
    // either with its own messages or with those of the scan still draining ahead of it.
    a_scan_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (mask != '0) |=> ##1 m_axis_tvalid)
        else $error("accepted scan produced no message");

    // A short release can never coincide with a long-press reading of the same lane.
    a_short_not_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        up_status.fire || down_status.fire |->
            !(up_status.fire && up_status.at_long) &&
            !(down_status.fire && down_status.at_long))
        else $error("short release reported together with long press");

endmodule

// ===== hdl/tkce_hold_lane.sv =====
// One hold-key lane: hold counter, armed flag and short-release detection.
// Depends on tkce_pkg for widths and the status struct.
module tkce_hold_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_now,
    input  logic                       i_before,
    input  logic [tkce_pkg::CNT_W-1:0] i_ticks,
    input  logic                       i_step,
    input  logic                       i_long_clear,
    output tkce_pkg::t_hold_status     o_status
);

    logic [tkce_pkg::CNT_W-1:0] r_count;
    logic                       r_armed;
    logic [tkce_pkg::CNT_W-1:0] n_count;
    logic                       n_armed;
    logic [tkce_pkg::CNT_W-1:0] base;

    always_comb begin
        // A fresh press restarts the count before this scan's increment.
        base    = (i_now && !i_before) ? '0 : r_count;
        n_count = r_count;
        n_armed = r_armed;
        if (i_now) begin
            n_count = (base == tkce_pkg::CNT_MAX) ? base : base + 16'd1;
            if (!i_before) begin
                n_armed = 1'b1;
            end
        end else if (i_before) begin
            n_count = '0;
            n_armed = 1'b0;
        end
        o_status.fire    = !i_now && i_before && r_armed && (r_count != '0) &&
                           (r_count < i_ticks);
        o_status.at_long = (n_count >= i_ticks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_armed <= 1'b0;
        end else if (i_step) begin
            r_count <= i_long_clear ? '0 : n_count;
            r_armed <= n_armed;
        end
    end

endmodule

// ===== hdl/tkce_merge.sv =====
// Merge stage: holds one waiting scan, drains the active one a message per ready beat.
// Depends on tkce_pkg for the batch and message types and the message table.
module tkce_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tkce_pkg::t_batch i_batch,
    output logic             o_valid,
    input  logic             i_ready,
    output tkce_pkg::t_msg   o_msg,
    output logic             o_last
);

    logic                           r_a_valid;
    tkce_pkg::t_batch               r_a;
    logic [tkce_pkg::NUM_SLOTS-1:0] r_b_mask;
    logic                           r_b_fan_one;
    logic                           r_b_fan_two;

    logic [tkce_pkg::NUM_SLOTS-1:0] lowest;
    logic [tkce_pkg::NUM_SLOTS-1:0] rest;
    logic                           b_free;
    logic                           a_moves;
    logic                           phase;

    assign lowest  = r_b_mask & (~r_b_mask + 11'd1);
    assign rest    = r_b_mask & ~lowest;
    assign o_valid = (r_b_mask != '0);
    assign o_last  = (rest == '0);
    assign b_free  = !o_valid || (i_ready && o_last);
    assign a_moves = r_a_valid && b_free;
    assign o_ready = !r_a_valid || a_moves;

    always_comb begin
        o_msg = '0;
        phase = 1'b0;
        for (int s = 0; s < tkce_pkg::NUM_SLOTS; s++) begin
            phase = (tkce_pkg::t_slot'(4'(s)) == tkce_pkg::SLOT_FAN_TWO) ? r_b_fan_two
                                                                         : r_b_fan_one;
            if (lowest[s]) begin
                o_msg = tkce_pkg::msg_entry(tkce_pkg::t_slot'(4'(s)), phase);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_mask  <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_a_valid <= 1'b1;
            end else if (a_moves) begin
                r_a_valid <= 1'b0;
            end
            if (a_moves) begin
                r_b_mask <= r_a.mask;
            end else if (o_valid && i_ready) begin
                r_b_mask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a <= i_batch;
        end
        if (a_moves) begin
            r_b_fan_one <= r_a.fan_one;
            r_b_fan_two <= r_a.fan_two;
        end
    end

endmodule
